@@ design/mnct_pkg.sv @@
// ----------------------------------------------------------------------------
// mnct_pkg
// Shared types and constants for the MIDI note and controller state tracker.
// ----------------------------------------------------------------------------
package mnct_pkg;

    // command codes carried on s_tuser
    localparam logic [2:0] CMD_NOTE_ON  = 3'd0;
    localparam logic [2:0] CMD_NOTE_OFF = 3'd1;
    localparam logic [2:0] CMD_CTRL     = 3'd2;
    localparam logic [2:0] CMD_WHEEL    = 3'd3;
    localparam logic [2:0] CMD_QUERY    = 3'd4;

    // controller numbers with special meaning
    localparam logic [6:0] CC_MOD_WHEEL      = 7'd1;
    localparam logic [6:0] CC_ALL_SOUND_OFF  = 7'd120;
    localparam logic [6:0] CC_RESET_ALL      = 7'd121;
    localparam logic [6:0] CC_ALL_NOTES_OFF  = 7'd123;

    localparam logic [13:0] BEND_CENTRE   = 14'd8192;
    localparam logic signed [14:0] BEND_MIN_STEP = 15'sd5;

    localparam logic [4:0] CHAN_MIN = 5'd1;
    localparam logic [4:0] CHAN_MAX = 5'd16;

    localparam logic [7:0] NO_NOTE = 8'hFF;

    // input payload, last field in the lowest bits
    typedef struct packed {
        logic        pad;
        logic [13:0] wheel_value;
        logic [6:0]  controller_value;
        logic [6:0]  controller_number;
        logic [6:0]  note_velocity;
        logic [6:0]  note_number;
        logic [4:0]  chan;
    } in_data_t;

    // result payload, last field in the lowest bits
    typedef struct packed {
        logic [5:0]  pad;
        logic [4:0]  touched_channel;
        logic [6:0]  touched_controller;
        logic [6:0]  cc_stored;
        logic        wheel_moved;
        logic        bend_moved;
        logic [6:0]  wheel_position;
        logic [13:0] bend_position;
        logic        recent_was_on;
        logic [6:0]  recent_velocity;
        logic [7:0]  recent_note;
        logic [6:0]  key_velocity;
        logic        key_held;
    } out_data_t;

endpackage

@@ design/mnct_ram.sv @@
// ----------------------------------------------------------------------------
// mnct_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module mnct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/midi_note_controller_tracker.sv @@
// ----------------------------------------------------------------------------
// midi_note_controller_tracker
// Tracks held keys, key velocities, recent note, pitch bend, mod wheel and a
// controller value store from a stream of decoded MIDI events.
// ----------------------------------------------------------------------------
// Each event passes through ST_IDLE, which reads the key entry and the
// controller entry from their synchronous memories, and ST_CALC, which
// updates them, writes them back and loads the result register; a new event
// is taken only once the last one is through. A waiting result stalls the
// update until it is taken. Both memories read as zero after reset through
// per-entry valid bits, and all-notes-off clears the key valid bits at once,
// so there is no clearing pass.
module midi_note_controller_tracker #(
    parameter int FIRST_KEY   = 21,
    parameter int KEY_COUNT   = 88,
    parameter int CC_COUNT    = 128,
    parameter int COUNT_WIDTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // chan, note_number, note_velocity, controller_number, controller_value,
    // wheel_value, zero pad
    input  logic [47:0] s_tdata,
    // cmd
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // key_held, key_velocity, recent_note, recent_velocity, recent_was_on,
    // bend_position, wheel_position, bend_moved, wheel_moved, cc_stored,
    // touched_controller, touched_channel, zero pad
    output logic [71:0] m_tdata
);

    localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int CW = (CC_COUNT > 1) ? $clog2(CC_COUNT) : 1;
    localparam int KEY_WORD = COUNT_WIDTH + 7;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } state_t;

    state_t                  state_reg, state_next;
    logic [2:0]              cmd_reg, cmd_next;
    mnct_pkg::in_data_t      in_reg, in_next;
    mnct_pkg::in_data_t      s_in;
    logic [KEY_COUNT-1:0]    key_valid_reg, key_valid_next;
    logic [CC_COUNT-1:0]     cc_valid_reg, cc_valid_next;
    logic [7:0]              last_note_reg, last_note_next;
    logic [6:0]              last_velocity_reg, last_velocity_next;
    logic                    last_on_reg, last_on_next;
    logic [13:0]             bend_reg, bend_next;
    logic [6:0]              wheel_reg, wheel_next;
    logic [6:0]              touched_cc_reg, touched_cc_next;
    logic [4:0]              touched_chan_reg, touched_chan_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    mnct_pkg::out_data_t     m_data_reg, m_data_next;

    logic                    accept;
    logic                    load;
    logic [7:0]              s_key_off;
    logic [7:0]              key_off;
    logic [KW-1:0]           key_idx;
    logic                    key_in;
    logic [CW-1:0]           cc_idx;
    logic                    cc_in;
    logic [KEY_WORD-1:0]     key_rd;
    logic [6:0]              cc_rd;
    logic                    key_we;
    logic [KEY_WORD-1:0]     key_wr;
    logic                    cc_we;
    logic [COUNT_WIDTH-1:0]  cnt_old, cnt_new;
    logic [6:0]              vel_old, vel_new;
    logic [6:0]              cc_old;
    logic                    note_on;
    logic                    note_evt;
    logic                    all_off;
    logic                    ctrl_evt;
    logic [13:0]             nb;
    logic signed [14:0]      bend_diff;

    assign s_in      = mnct_pkg::in_data_t'(s_tdata);
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_data_reg;
    assign s_key_off = {1'b0, s_in.note_number} - 8'(FIRST_KEY);

    mnct_ram #(
        .WIDTH (KEY_WORD),
        .DEPTH (KEY_COUNT)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (key_we),
        .wr_addr (key_idx),
        .wr_data (key_wr),
        .rd_en   (accept),
        .rd_addr (s_key_off[KW-1:0]),
        .rd_data (key_rd)
    );

    mnct_ram #(
        .WIDTH (7),
        .DEPTH (CC_COUNT)
    ) u_cc_ram (
        .aclk    (aclk),
        .wr_en   (cc_we),
        .wr_addr (cc_idx),
        .wr_data (in_reg.controller_value),
        .rd_en   (accept),
        .rd_addr (s_in.controller_number[CW-1:0]),
        .rd_data (cc_rd)
    );

    // key and controller decode of the held event
    always_comb begin
        key_off  = {1'b0, in_reg.note_number} - 8'(FIRST_KEY);
        key_idx  = key_off[KW-1:0];
        key_in   = ({1'b0, in_reg.note_number} >= 8'(FIRST_KEY)) && (key_off < 8'(KEY_COUNT));
        cc_idx   = in_reg.controller_number[CW-1:0];
        cc_in    = {1'b0, in_reg.controller_number} < 8'(CC_COUNT);
        load     = (state_reg == ST_CALC) && (!m_tvalid_reg || m_tready);

        cnt_old  = '0;
        vel_old  = '0;
        if (key_in && key_valid_reg[key_idx]) begin
            cnt_old = key_rd[COUNT_WIDTH-1:0];
            vel_old = key_rd[KEY_WORD-1:COUNT_WIDTH];
        end
        cc_old = (cc_in && cc_valid_reg[cc_idx]) ? cc_rd : 7'd0;

        note_on  = (cmd_reg == mnct_pkg::CMD_NOTE_ON) && (in_reg.note_velocity != 7'd0);
        note_evt = ((cmd_reg == mnct_pkg::CMD_NOTE_ON) || (cmd_reg == mnct_pkg::CMD_NOTE_OFF))
                   && key_in;
        all_off  = (cmd_reg == mnct_pkg::CMD_CTRL)
                   && ((in_reg.controller_number == mnct_pkg::CC_ALL_NOTES_OFF)
                       || (in_reg.controller_number == mnct_pkg::CC_ALL_SOUND_OFF));
        ctrl_evt = (cmd_reg == mnct_pkg::CMD_CTRL) && !all_off;

        if (note_on) begin
            cnt_new = (cnt_old == CNT_MAX) ? cnt_old : cnt_old + 1'b1;
            vel_new = in_reg.note_velocity;
        end else begin
            cnt_new = (cnt_old == '0) ? cnt_old : cnt_old - 1'b1;
            vel_new = (cnt_new == '0) ? 7'd0 : vel_old;
        end

        key_we = load && note_evt;
        key_wr = {vel_new, cnt_new};
        cc_we  = load && ctrl_evt && cc_in;

        nb        = in_reg.wheel_value - mnct_pkg::BEND_CENTRE;
        bend_diff = $signed({nb[13], nb}) - $signed({bend_reg[13], bend_reg});
    end

    // sequencing and state update
    always_comb begin
        state_next         = state_reg;
        cmd_next           = cmd_reg;
        in_next            = in_reg;
        key_valid_next     = key_valid_reg;
        cc_valid_next      = cc_valid_reg;
        last_note_next     = last_note_reg;
        last_velocity_next = last_velocity_reg;
        last_on_next       = last_on_reg;
        bend_next          = bend_reg;
        wheel_next         = wheel_reg;
        touched_cc_next    = touched_cc_reg;
        touched_chan_next  = touched_chan_reg;
        m_tvalid_next      = m_tvalid_reg && !m_tready;
        m_data_next        = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next   = s_tuser;
                    in_next    = s_in;
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (load) begin
                    m_data_next             = '0;
                    m_data_next.bend_moved  = 1'b0;
                    m_data_next.wheel_moved = 1'b0;

                    if (note_evt) begin
                        key_valid_next[key_idx] = 1'b1;
                        last_note_next          = {1'b0, in_reg.note_number};
                        last_velocity_next      = in_reg.note_velocity;
                        last_on_next            = note_on;
                    end

                    if (all_off) begin
                        key_valid_next     = '0;
                        last_note_next     = mnct_pkg::NO_NOTE;
                        last_velocity_next = 7'd0;
                        last_on_next       = 1'b0;
                        if (in_reg.controller_number == mnct_pkg::CC_ALL_SOUND_OFF) begin
                            bend_next               = '0;
                            wheel_next              = '0;
                            m_data_next.bend_moved  = 1'b1;
                            m_data_next.wheel_moved = 1'b1;
                        end
                    end

                    if (ctrl_evt) begin
                        if (cc_in) begin
                            cc_valid_next[cc_idx] = 1'b1;
                            touched_cc_next       = in_reg.controller_number;
                            if (in_reg.chan < mnct_pkg::CHAN_MIN) begin
                                touched_chan_next = mnct_pkg::CHAN_MIN;
                            end else if (in_reg.chan > mnct_pkg::CHAN_MAX) begin
                                touched_chan_next = mnct_pkg::CHAN_MAX;
                            end else begin
                                touched_chan_next = in_reg.chan;
                            end
                        end
                        if (in_reg.controller_number == mnct_pkg::CC_MOD_WHEEL) begin
                            m_data_next.wheel_moved = (in_reg.controller_value != wheel_reg);
                            wheel_next              = in_reg.controller_value;
                        end else if (in_reg.controller_number == mnct_pkg::CC_RESET_ALL) begin
                            bend_next               = '0;
                            wheel_next              = '0;
                            m_data_next.bend_moved  = 1'b1;
                            m_data_next.wheel_moved = 1'b1;
                        end
                    end

                    if (cmd_reg == mnct_pkg::CMD_WHEEL) begin
                        m_data_next.bend_moved = (bend_diff >= mnct_pkg::BEND_MIN_STEP)
                                              || (bend_diff <= -mnct_pkg::BEND_MIN_STEP);
                        bend_next              = nb;
                    end

                    // key report, a query leaves everything untouched
                    if (!key_in || all_off) begin
                        m_data_next.key_held     = 1'b0;
                        m_data_next.key_velocity = 7'd0;
                    end else if (note_evt) begin
                        m_data_next.key_held     = (cnt_new != '0);
                        m_data_next.key_velocity = vel_new;
                    end else begin
                        m_data_next.key_held     = (cnt_old != '0);
                        m_data_next.key_velocity = vel_old;
                    end

                    if (!cc_in) begin
                        m_data_next.cc_stored = 7'd0;
                    end else if (ctrl_evt) begin
                        m_data_next.cc_stored = in_reg.controller_value;
                    end else begin
                        m_data_next.cc_stored = cc_old;
                    end

                    m_data_next.recent_note        = last_note_next;
                    m_data_next.recent_velocity    = last_velocity_next;
                    m_data_next.recent_was_on      = last_on_next;
                    m_data_next.bend_position      = bend_next;
                    m_data_next.wheel_position     = wheel_next;
                    m_data_next.touched_controller = touched_cc_next;
                    m_data_next.touched_channel    = touched_chan_next;
                    m_tvalid_next                  = 1'b1;
                    state_next                     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            key_valid_reg     <= '0;
            cc_valid_reg      <= '0;
            last_note_reg     <= mnct_pkg::NO_NOTE;
            last_velocity_reg <= '0;
            last_on_reg       <= 1'b0;
            bend_reg          <= '0;
            wheel_reg         <= '0;
            touched_cc_reg    <= '0;
            touched_chan_reg  <= mnct_pkg::CHAN_MIN;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg         <= state_next;
            key_valid_reg     <= key_valid_next;
            cc_valid_reg      <= cc_valid_next;
            last_note_reg     <= last_note_next;
            last_velocity_reg <= last_velocity_next;
            last_on_reg       <= last_on_next;
            bend_reg          <= bend_next;
            wheel_reg         <= wheel_next;
            touched_cc_reg    <= touched_cc_next;
            touched_chan_reg  <= touched_chan_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
        cmd_reg    <= cmd_next;
        in_reg     <= in_next;
        m_data_reg <= m_data_next;
    end

endmodule

@@ design/mnct_checker.sv @@
// ----------------------------------------------------------------------------
// mnct_checker
// Port-level checks for the MIDI note and controller state tracker.
// ----------------------------------------------------------------------------
module mnct_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    mnct_pkg::out_data_t res;
    assign res = mnct_pkg::out_data_t'(m_tdata);

    // one transaction in flight on the input side
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on back-to-back cycles");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a held key always carries a nonzero velocity, a released one zero
    a_held_vel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res.key_held == (res.key_velocity != 7'd0)))
        else $error("key held flag and velocity disagree");

    a_chan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res.touched_channel >= mnct_pkg::CHAN_MIN)
                     && (res.touched_channel <= mnct_pkg::CHAN_MAX))
        else $error("touched channel out of range");

    a_note_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!res.recent_note[7] || (res.recent_note == mnct_pkg::NO_NOTE)))
        else $error("recent note below minus one");

endmodule

bind midi_note_controller_tracker mnct_checker u_mnct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
